/* rtl/wma_pkg.sv */
package wma_pkg;

  // window length and derived widths
  localparam int WINDOW = 256;
  localparam int DATA_W = 32;
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int BIT_W  = $clog2(SUM_W);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [PTR_W-1:0]         ptr_t;

endpackage

/* rtl/wma_in_if.sv */
interface wma_in_if;
  logic                    valid;
  logic                    ready;
  logic [wma_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/wma_out_if.sv */
interface wma_out_if;
  logic                    valid;
  logic                    ready;
  logic [wma_pkg::DATA_W-1:0] average;
  logic                    window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink   (input valid, input average, input window_full, output ready);
endinterface

/* rtl/windowed_moving_average.sv */
// channel   dir  payload                          transfer when
// in_s      in   sample (signed Q16.16)            valid && ready
// out_m     out  average (signed Q16.16), full     valid && ready
//
// each sample passes through these steps: accept it and read the oldest entry,
// update the sum, run SUM_W steps of the restoring divider, then load the
// output register.
// a finished result may wait in the output register while the next sample is
// accepted; the sequencer holds in its final state only if that register is full.
// synchronous reset clears pointer, count, sum and handshake state, not the store
module windowed_moving_average (
  input  logic      clk,
  input  logic      rst_n,
  wma_in_if.sink    in_s,
  wma_out_if.source out_m
);
  import wma_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state_r, state_nxt;

  // sample store
  sample_t store_mem [WINDOW];
  sample_t rd_data_r;
  logic    wr_en;

  // running state
  ptr_t    wp_r, wp_nxt;
  count_t  cnt_r, cnt_nxt;
  sum_t    sum_r, sum_nxt;
  sample_t sample_r;

  // divider registers
  logic [SUM_W-1:0] quo_r, quo_nxt;
  count_t           rem_r, rem_nxt;
  count_t           div_r, div_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             neg_r, neg_nxt;
  logic             full_r, full_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] avg_r, avg_nxt;
  logic            ofull_r, ofull_nxt;

  logic in_xfer, out_free;
  logic was_full;
  sum_t add_term, sub_term;
  logic [CNT_W:0] rem_sh;
  logic [SUM_W-1:0] res_mag;

  assign in_s.ready        = (state_r == S_IDLE);
  assign in_xfer           = in_s.valid && in_s.ready;
  assign out_m.valid       = out_valid_r;
  assign out_m.average     = avg_r;
  assign out_m.window_full = ofull_r;
  assign out_free          = !out_valid_r || out_m.ready;

  // store write on the sum step, registered read at the write pointer
  assign wr_en = (state_r == S_SUM);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wp_r] <= sample_r;
    end
    rd_data_r <= store_mem[wp_r];
  end

  // sum update, divider step and output register load
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    bit_nxt       = bit_r;
    neg_nxt       = neg_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    avg_nxt       = avg_r;
    ofull_nxt     = ofull_r;

    was_full = (cnt_r == CNT_W'(WINDOW));
    add_term = sum_t'({{(SUM_W-DATA_W){sample_r[DATA_W-1]}}, sample_r});
    sub_term = was_full ? sum_t'({{(SUM_W-DATA_W){rd_data_r[DATA_W-1]}}, rd_data_r})
                        : '0;
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    res_mag  = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

    if (out_valid_r && out_m.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt  = sum_r + add_term - sub_term;
        cnt_nxt  = was_full ? cnt_r : cnt_r + CNT_W'(1);
        full_nxt = was_full || (cnt_r == CNT_W'(WINDOW - 1));
        wp_nxt   = (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
        neg_nxt  = sum_nxt[SUM_W-1];
        quo_nxt  = sum_nxt[SUM_W-1] ? (~sum_nxt + SUM_W'(1)) : sum_nxt;
        rem_nxt  = '0;
        div_nxt  = cnt_nxt;
        bit_nxt  = BIT_W'(SUM_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // one restoring step per cycle
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = CNT_W'(rem_sh - {1'b0, div_r});
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        if (bit_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          avg_nxt       = res_mag[DATA_W-1:0];
          ofull_nxt     = full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_s.sample;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    bit_r   <= bit_nxt;
    neg_r   <= neg_nxt;
    full_r  <= full_nxt;
    avg_r   <= avg_nxt;
    ofull_r <= ofull_nxt;
  end

  // fill count never passes the window length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("fill count above window");

  // an accepted sample goes straight to the sum step
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SUM))
    else $error("sum step did not follow transfer");

  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r != '0))
    else $error("zero divisor");

  // a new result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_m.ready) |=> (out_valid_r && $stable(avg_r)))
    else $error("pending result overwritten");

  // a full flag in a result means the count has reached the window
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && full_r) |-> (cnt_r == CNT_W'(WINDOW)))
    else $error("full flag without full count");

endmodule
